@@ sv/assert_macros.svh @@
// assertion macros shared by the lock unit rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds in the same cycle as its condition
`define CHECK_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that holds in the cycle after its condition
`define CHECK_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pilu_pkg.sv @@
// shared types and codes for the priority inheritance lock unit
// no dependencies; used by the channel interfaces and the top level
package pilu_pkg;

    // port field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 3;
    localparam int QCOUNT_W = 5;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [ID_W-1:0]     id_t;
    typedef logic [PRIO_W-1:0]   prio_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [QCOUNT_W-1:0] qcount_t;

    // request commands
    localparam cmd_t CMD_LOCK    = 2'd0;
    localparam cmd_t CMD_TRYLOCK = 2'd1;
    localparam cmd_t CMD_UNLOCK  = 2'd2;

    // result status codes
    localparam status_t STAT_ACQUIRED = 3'd0;
    localparam status_t STAT_DEADLOCK = 3'd1;
    localparam status_t STAT_BUSY     = 3'd2;
    localparam status_t STAT_QUEUED   = 3'd3;
    localparam status_t STAT_FULL     = 3'd4;
    localparam status_t STAT_RELEASED = 3'd5;
    localparam status_t STAT_WOKE     = 3'd6;

endpackage

@@ sv/pilu_if.sv @@
// request and response channel interfaces of the lock unit
// depends on pilu_pkg for field types

// request channel: command, thread and priority
interface pilu_req_if
    import pilu_pkg::*;
    ();
    logic  valid;
    logic  ready;
    cmd_t  cmd;
    id_t   thread_id;
    prio_t priority_req;

    modport source (output valid, output cmd, output thread_id, output priority_req,
                    input ready);
    modport sink   (input valid, input cmd, input thread_id, input priority_req,
                    output ready);
endinterface

// response channel: one result per request
interface pilu_rsp_if
    import pilu_pkg::*;
    ();
    logic    valid;
    logic    ready;
    status_t status;
    logic    owner_held;
    id_t     owner_id;
    prio_t   owner_priority;
    logic    woken_valid;
    id_t     woken_id;
    qcount_t queue_count;

    modport source (output valid, output status, output owner_held, output owner_id,
                    output owner_priority, output woken_valid, output woken_id,
                    output queue_count, input ready);
    modport sink   (input valid, input status, input owner_held, input owner_id,
                    input owner_priority, input woken_valid, input woken_id,
                    input queue_count, output ready);
endinterface

@@ sv/pilu_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module pilu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ sv/priority_inheritance_lock_unit.sv @@
// top level of the priority inheritance lock unit
// depends on pilu_pkg, pilu_if, pilu_ram and assert_macros.svh
//
//   channel | dir | fields
//   --------+-----+----------------------------------------------------------
//   req     | in  | cmd, thread_id, priority_req
//   rsp     | out | status, owner_held, owner_id, owner_priority,
//           |     | woken_valid, woken_id, queue_count
//
// trylock, unlock with an empty queue, deadlock, an unused cmd and a lock on a free
// mutex go from idle straight to done; a lock on a held mutex with an empty queue
// passes through place. otherwise a lock on a held mutex sweeps the waiter ram
// through its single read port and stops there when already queued or full; else it
// places the waiter at the tail, or first shifts the entries from pos up by one.
// unlock with waiters reads every entry once to pop the head.
// reset clears the lock state and the waiter count; the ram needs no clearing pass.
// req is taken only while the sequencer is idle; a result waiting on rsp holds back
// the next result, not the next transfer on req.
`include "assert_macros.svh"

module priority_inheritance_lock_unit
    import pilu_pkg::*;
#(
    parameter int MAX_WAITERS = 16,
    parameter int ID_BITS     = 8,
    parameter int PRIO_BITS   = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    pilu_req_if.sink   req,
    pilu_rsp_if.source rsp
);

    localparam int IW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int PW = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;
    localparam int EW = IW + PW;
    localparam int AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CW = $clog2(MAX_WAITERS + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SHIFT_DN = 3'd2;
    localparam logic [2:0] S_PLACE    = 3'd3;
    localparam logic [2:0] S_POP      = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    // control and lock state
    logic [2:0]    state_reg, state_next;
    logic          held_reg, held_next;
    logic [IW-1:0] holder_reg, holder_next;
    logic [PW-1:0] holder_prio_reg, holder_prio_next;
    logic [PW-1:0] saved_prio_reg, saved_prio_next;
    logic          saved_valid_reg, saved_valid_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    logic          rd_more_reg, rd_more_next;
    logic          rd_vld_reg, rd_vld_next;

    // per request working registers
    logic [IW-1:0] req_id_reg, req_id_next;
    logic [PW-1:0] req_prio_reg, req_prio_next;
    status_t       status_reg, status_next;
    logic          prio_given_reg, prio_given_next;
    logic [PW-1:0] given_prio_reg, given_prio_next;
    logic          woke_reg, woke_next;
    logic [IW-1:0] woken_reg, woken_next;
    logic          found_reg, found_next;
    logic          pos_set_reg, pos_set_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] dat_idx_reg, dat_idx_next;

    // result register
    status_t       o_status_reg, o_status_next;
    logic          o_held_reg, o_held_next;
    id_t           o_owner_reg, o_owner_next;
    prio_t         o_prio_reg, o_prio_next;
    logic          o_woke_reg, o_woke_next;
    id_t           o_woken_reg, o_woken_next;
    qcount_t       o_count_reg, o_count_next;

    // waiter ram port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    logic [IW-1:0] rd_id;
    logic [PW-1:0] rd_prio;
    logic [IW-1:0] in_id;
    logic [PW-1:0] in_prio;
    logic [CW-1:0] count_m1;
    logic          accept;

    // waiter queue, sorted by falling priority, entry is {id, prio}
    pilu_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WAITERS)
    ) u_wait_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_id    = ram_rdata[EW-1:PW];
    assign rd_prio  = ram_rdata[PW-1:0];
    assign in_id    = req.thread_id[IW-1:0];
    assign in_prio  = req.priority_req[PW-1:0];
    assign count_m1 = count_reg - CW'(1);
    assign accept   = req.valid && req.ready;

    assign req.ready = (state_reg == S_IDLE);

    // sequencer and read-modify-write of the waiter ram
    always_comb
    begin
        state_next       = state_reg;
        held_next        = held_reg;
        holder_next      = holder_reg;
        holder_prio_next = holder_prio_reg;
        saved_prio_next  = saved_prio_reg;
        saved_valid_next = saved_valid_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        rd_more_next     = rd_more_reg;
        rd_vld_next      = 1'b0;
        req_id_next      = req_id_reg;
        req_prio_next    = req_prio_reg;
        status_next      = status_reg;
        prio_given_next  = prio_given_reg;
        given_prio_next  = given_prio_reg;
        woke_next        = woke_reg;
        woken_next       = woken_reg;
        found_next       = found_reg;
        pos_set_next     = pos_set_reg;
        pos_next         = pos_reg;
        rd_idx_next      = rd_idx_reg;
        dat_idx_next     = dat_idx_reg;
        o_status_next    = o_status_reg;
        o_held_next      = o_held_reg;
        o_owner_next     = o_owner_reg;
        o_prio_next      = o_prio_reg;
        o_woke_next      = o_woke_reg;
        o_woken_next     = o_woken_reg;
        o_count_next     = o_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = rd_idx_reg;

        // result taken downstream
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_id_next     = in_id;
                    req_prio_next   = in_prio;
                    prio_given_next = 1'b0;
                    given_prio_next = '0;
                    woke_next       = 1'b0;
                    woken_next      = '0;
                    found_next      = 1'b0;
                    pos_set_next    = 1'b0;
                    pos_next        = count_reg;
                    rd_idx_next     = '0;
                    rd_more_next    = 1'b1;
                    status_next     = STAT_BUSY;
                    state_next      = S_DONE;
                    case (req.cmd)
                        CMD_LOCK:
                        begin
                            if (!held_reg)
                            begin
                                held_next        = 1'b1;
                                holder_next      = in_id;
                                holder_prio_next = in_prio;
                                saved_valid_next = 1'b0;
                                saved_prio_next  = '0;
                                status_next      = STAT_ACQUIRED;
                            end
                            else if (holder_reg == in_id)
                            begin
                                status_next = STAT_DEADLOCK;
                            end
                            else
                            begin
                                // boost the holder, keep the first pre-boost value
                                if (holder_prio_reg < in_prio)
                                begin
                                    holder_prio_next = in_prio;
                                    if (!saved_valid_reg)
                                    begin
                                        saved_prio_next  = holder_prio_reg;
                                        saved_valid_next = 1'b1;
                                    end
                                end
                                if (count_reg == '0)
                                begin
                                    state_next = S_PLACE;
                                end
                                else
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        CMD_TRYLOCK:
                        begin
                            if (!held_reg)
                            begin
                                held_next        = 1'b1;
                                holder_next      = in_id;
                                holder_prio_next = in_prio;
                                saved_valid_next = 1'b0;
                                saved_prio_next  = '0;
                                status_next      = STAT_ACQUIRED;
                            end
                        end
                        CMD_UNLOCK:
                        begin
                            prio_given_next = 1'b1;
                            if (held_reg)
                            begin
                                given_prio_next = saved_valid_reg ? saved_prio_reg
                                                                  : holder_prio_reg;
                            end
                            saved_valid_next = 1'b0;
                            saved_prio_next  = '0;
                            held_next        = 1'b0;
                            holder_next      = '0;
                            holder_prio_next = '0;
                            if (count_reg == '0)
                            begin
                                status_next = STAT_RELEASED;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_BUSY;
                        end
                    endcase
                end
            end

            // sweep the queue: membership and insertion point
            S_SCAN:
            begin
                if (rd_more_reg)
                begin
                    rd_vld_next  = 1'b1;
                    dat_idx_next = rd_idx_reg;
                    if (CW'(rd_idx_reg) == count_m1)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                    end
                end
                if (rd_vld_reg)
                begin
                    if (rd_id == req_id_reg)
                    begin
                        found_next = 1'b1;
                    end
                    if (!pos_set_reg && (rd_prio < req_prio_reg))
                    begin
                        pos_set_next = 1'b1;
                        pos_next     = CW'(dat_idx_reg);
                    end
                end
                if (!rd_more_reg && !rd_vld_reg)
                begin
                    if (found_reg)
                    begin
                        status_next = STAT_QUEUED;
                        state_next  = S_DONE;
                    end
                    else if (count_reg == CW'(MAX_WAITERS))
                    begin
                        status_next = STAT_FULL;
                        state_next  = S_DONE;
                    end
                    else if (pos_reg == count_reg)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_idx_next  = AW'(count_m1);
                        rd_more_next = 1'b1;
                        state_next   = S_SHIFT_DN;
                    end
                end
            end

            // move entries pos..count-1 up by one, from the tail
            S_SHIFT_DN:
            begin
                if (rd_more_reg)
                begin
                    rd_vld_next  = 1'b1;
                    dat_idx_next = rd_idx_reg;
                    if (CW'(rd_idx_reg) == pos_reg)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - AW'(1);
                    end
                end
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(CW'(dat_idx_reg) + CW'(1));
                    ram_wdata = ram_rdata;
                end
                if (!rd_more_reg && !rd_vld_reg)
                begin
                    state_next = S_PLACE;
                end
            end

            // write the new waiter into its slot
            S_PLACE:
            begin
                ram_we      = 1'b1;
                ram_waddr   = AW'(pos_reg);
                ram_wdata   = {req_id_reg, req_prio_reg};
                count_next  = count_reg + CW'(1);
                status_next = STAT_QUEUED;
                state_next  = S_DONE;
            end

            // read the head, move the rest down by one
            S_POP:
            begin
                if (rd_more_reg)
                begin
                    rd_vld_next  = 1'b1;
                    dat_idx_next = rd_idx_reg;
                    if (CW'(rd_idx_reg) == count_m1)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                    end
                end
                if (rd_vld_reg)
                begin
                    if (dat_idx_reg == '0)
                    begin
                        woke_next  = 1'b1;
                        woken_next = rd_id;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = dat_idx_reg - AW'(1);
                        ram_wdata = ram_rdata;
                    end
                end
                if (!rd_more_reg && !rd_vld_reg)
                begin
                    count_next  = count_m1;
                    status_next = STAT_WOKE;
                    state_next  = S_DONE;
                end
            end

            // load the result register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = status_reg;
                    o_held_next    = held_reg;
                    o_owner_next   = held_reg ? ID_W'(holder_reg) : '0;
                    if (prio_given_reg)
                    begin
                        o_prio_next = PRIO_W'(given_prio_reg);
                    end
                    else
                    begin
                        o_prio_next = held_reg ? PRIO_W'(holder_prio_reg) : '0;
                    end
                    o_woke_next  = woke_reg;
                    o_woken_next = woke_reg ? ID_W'(woken_reg) : '0;
                    o_count_next = QCOUNT_W'(count_reg);
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            held_reg        <= 1'b0;
            holder_reg      <= '0;
            holder_prio_reg <= '0;
            saved_prio_reg  <= '0;
            saved_valid_reg <= 1'b0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            rd_more_reg     <= 1'b0;
            rd_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            held_reg        <= held_next;
            holder_reg      <= holder_next;
            holder_prio_reg <= holder_prio_next;
            saved_prio_reg  <= saved_prio_next;
            saved_valid_reg <= saved_valid_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
            rd_more_reg     <= rd_more_next;
            rd_vld_reg      <= rd_vld_next;
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        req_id_reg     <= req_id_next;
        req_prio_reg   <= req_prio_next;
        status_reg     <= status_next;
        prio_given_reg <= prio_given_next;
        given_prio_reg <= given_prio_next;
        woke_reg       <= woke_next;
        woken_reg      <= woken_next;
        found_reg      <= found_next;
        pos_set_reg    <= pos_set_next;
        pos_reg        <= pos_next;
        rd_idx_reg     <= rd_idx_next;
        dat_idx_reg    <= dat_idx_next;
        o_status_reg   <= o_status_next;
        o_held_reg     <= o_held_next;
        o_owner_reg    <= o_owner_next;
        o_prio_reg     <= o_prio_next;
        o_woke_reg     <= o_woke_next;
        o_woken_reg    <= o_woken_next;
        o_count_reg    <= o_count_next;
    end

    // response channel
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = o_status_reg;
    assign rsp.owner_held     = o_held_reg;
    assign rsp.owner_id       = o_owner_reg;
    assign rsp.owner_priority = o_prio_reg;
    assign rsp.woken_valid    = o_woke_reg;
    assign rsp.woken_id       = o_woken_reg;
    assign rsp.queue_count    = o_count_reg;

    // checks
    `CHECK_IMP(a_count_bound, 1'b1, count_reg <= CW'(MAX_WAITERS),
               "waiter count overflow")
    `CHECK_IMP(a_free_no_save, !held_reg, !saved_valid_reg,
               "saved priority on free lock")
    `CHECK_IMP(a_boost_order, held_reg && saved_valid_reg, holder_prio_reg > saved_prio_reg,
               "boost not above saved priority")
    `CHECK_IMP(a_ram_write_state, ram_we,
               (state_reg == S_SHIFT_DN) || (state_reg == S_PLACE) || (state_reg == S_POP),
               "ram write outside update states")
    `CHECK_NXT(a_accept_busy, accept, state_reg != S_IDLE,
               "sequencer idle after transfer")

endmodule

@@ tb/sv/priority_inheritance_lock_unit_tb.sv @@
// testbench for the priority inheritance lock unit: directed and random requests,
// every response checked against a behavioral model of the mutex and its waiter queue
// depends on pilu_pkg, pilu_if and the priority_inheritance_lock_unit rtl
import pilu_pkg::*;

localparam int WAITER_SLOTS = 16;

// one response as seen on the rsp channel
typedef struct packed {
    status_t status;
    logic    owner_held;
    id_t     owner_id;
    prio_t   owner_priority;
    logic    woken_valid;
    id_t     woken_id;
    qcount_t queue_count;
} lock_rsp_t;

// mutex model plus the queue of responses still owed by the unit
class lock_checker;
    bit        held;
    id_t       holder;
    prio_t     holder_prio;
    prio_t     saved_prio;
    bit        saved_valid;
    id_t       waiter_ids[$];
    prio_t     waiter_prios[$];
    bit        woke;
    id_t       woken_thread;
    lock_rsp_t expected_rsp[$];
    int        mismatches;

    function new();
        held        = 1'b0;
        holder      = '0;
        holder_prio = '0;
        saved_prio  = '0;
        saved_valid = 1'b0;
        woke        = 1'b0;
        mismatches  = 0;
    endfunction

    function void take_lock(id_t id, prio_t p);
        held        = 1'b1;
        holder      = id;
        holder_prio = p;
        saved_valid = 1'b0;
        saved_prio  = '0;
    endfunction

    // update the mutex for one accepted request and queue the response it owes
    function void note_request(cmd_t c, id_t id, prio_t p);
        lock_rsp_t r;
        prio_t     out_prio;
        bit        prio_given;
        bit        queued;
        int        pos;
        r          = '0;
        r.status   = STAT_BUSY;
        out_prio   = '0;
        prio_given = 1'b0;
        woke       = 1'b0;
        case (c)
            CMD_LOCK:
            begin
                if (!held)
                begin
                    take_lock(id, p);
                    r.status = STAT_ACQUIRED;
                end
                else if (holder == id)
                    r.status = STAT_DEADLOCK;
                else
                begin
                    // inherit the waiter's priority, keep the first pre-boost value
                    if (holder_prio < p)
                    begin
                        if (!saved_valid)
                        begin
                            saved_prio  = holder_prio;
                            saved_valid = 1'b1;
                        end
                        holder_prio = p;
                    end
                    queued = 1'b0;
                    foreach (waiter_ids[i])
                        if (waiter_ids[i] == id)
                            queued = 1'b1;
                    if (queued)
                        r.status = STAT_QUEUED;
                    else if (waiter_ids.size() >= WAITER_SLOTS)
                        r.status = STAT_FULL;
                    else
                    begin
                        // ahead of the first lower priority, behind equal ones
                        pos = waiter_ids.size();
                        for (int i = waiter_ids.size() - 1; i >= 0; i--)
                            if (waiter_prios[i] < p)
                                pos = i;
                        waiter_ids.insert(pos, id);
                        waiter_prios.insert(pos, p);
                        r.status = STAT_QUEUED;
                    end
                end
            end
            CMD_TRYLOCK:
            begin
                if (!held)
                begin
                    take_lock(id, p);
                    r.status = STAT_ACQUIRED;
                end
            end
            CMD_UNLOCK:
            begin
                if (held)
                begin
                    if (saved_valid)
                        holder_prio = saved_prio;
                    out_prio = holder_prio;
                end
                saved_valid = 1'b0;
                saved_prio  = '0;
                prio_given  = 1'b1;
                // pop the head waiter, any caller releases
                if (waiter_ids.size() > 0)
                begin
                    woke         = 1'b1;
                    woken_thread = waiter_ids.pop_front();
                    void'(waiter_prios.pop_front());
                    r.woken_valid = 1'b1;
                    r.woken_id    = woken_thread;
                end
                held        = 1'b0;
                holder      = '0;
                holder_prio = '0;
                r.status    = woke ? STAT_WOKE : STAT_RELEASED;
            end
            default: ;
        endcase
        if (!prio_given)
            out_prio = held ? holder_prio : '0;
        r.owner_held     = held;
        r.owner_id       = held ? holder : '0;
        r.owner_priority = out_prio;
        r.queue_count    = qcount_t'(waiter_ids.size());
        expected_rsp.push_back(r);
    endfunction

    function string describe(lock_rsp_t r);
        return $sformatf("status %0d held %0d owner %0d prio %0d woke %0d woken %0d count %0d",
                         r.status, r.owner_held, r.owner_id, r.owner_priority,
                         r.woken_valid, r.woken_id, r.queue_count);
    endfunction

    // compare one response with the oldest one owed
    function void check_response(lock_rsp_t got);
        lock_rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response: %s", describe(got));
            return;
        end
        want = expected_rsp.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("response mismatch: expected %s, got %s",
                         describe(want), describe(got));
        end
    endfunction
endclass

module priority_inheritance_lock_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   CYCLE_LIMIT  = 1_000_000;
    localparam int   RANDOM_ITEMS = 1100;
    localparam int   DRAIN_CYCLES = 60;
    localparam int   IDLE_PERCENT = 27;
    localparam cmd_t CMD_UNUSED   = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    bit          steady = 1'b0;
    int          cycles = 0;
    int          issued = 0;
    lock_checker ledger;

    pilu_req_if req ();
    pilu_rsp_if rsp ();

    priority_inheritance_lock_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("priority_inheritance_lock_unit_tb failed");
            $finish;
        end
    end

    // response side stalls at random except during the steady stretch
    always @(posedge clk)
        rsp.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

    // check every response transfer
    always @(posedge clk)
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            ledger.check_response(lock_rsp_t'{status: rsp.status,
                                              owner_held: rsp.owner_held,
                                              owner_id: rsp.owner_id,
                                              owner_priority: rsp.owner_priority,
                                              woken_valid: rsp.woken_valid,
                                              woken_id: rsp.woken_id,
                                              queue_count: rsp.queue_count});

    // mostly a small pool of threads so requests collide, sometimes any id
    function automatic id_t pick_thread();
        if ($urandom_range(7) == 0)
            return id_t'($urandom_range(255));
        return id_t'($urandom_range(19) * 13);
    endfunction

    // priorities cluster on a few levels to exercise ties
    function automatic prio_t pick_prio();
        if ($urandom_range(3) == 0)
            return prio_t'($urandom_range(3) * 85);
        return prio_t'($urandom_range(255));
    endfunction

    // one request transfer, with random idle cycles ahead of it
    task automatic send_request(cmd_t c, id_t id, prio_t p);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.cmd          <= c;
        req.thread_id    <= id;
        req.priority_req <= p;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        ledger.note_request(c, id, p);
        if (c != CMD_UNUSED)
            issued++;
    endtask

    // unstructured request, unlocks usually from the holder
    task automatic send_random_request();
        int   roll;
        cmd_t c;
        id_t  id;
        roll = $urandom_range(99);
        if (roll < 45)
            c = CMD_LOCK;
        else if (roll < 65)
            c = CMD_TRYLOCK;
        else if (roll < 95)
            c = CMD_UNLOCK;
        else
            c = CMD_UNUSED;
        id = pick_thread();
        if (ledger.held && $urandom_range(9) < ((c == CMD_UNLOCK) ? 7 : 1))
            id = ledger.holder;
        send_request(c, id, pick_prio());
    endtask

    initial
    begin
        int  waiters;
        int  handoffs;
        int  start;
        id_t id;
        ledger           = new();
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.cmd          = CMD_LOCK;
        req.thread_id    = '0;
        req.priority_req = '0;
        rsp.ready        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corner cases of the lock and the waiter queue
        send_request(CMD_UNLOCK, 8'd0, 8'd0);
        send_request(CMD_UNUSED, 8'hff, 8'hff);
        send_request(CMD_TRYLOCK, 8'h80, 8'd0);
        send_request(CMD_LOCK, 8'h80, 8'd7);
        send_request(CMD_TRYLOCK, 8'd1, 8'hff);
        for (int i = 1; i <= 15; i++)
            send_request(CMD_LOCK, id_t'(i), (i % 4 == 0) ? 8'd100 : prio_t'(i * 17));
        send_request(CMD_LOCK, 8'd16, 8'd0);
        send_request(CMD_LOCK, 8'hff, 8'hff);
        send_request(CMD_LOCK, 8'd3, 8'd200);
        send_request(CMD_UNLOCK, 8'd200, 8'd0);
        send_request(CMD_LOCK, 8'd5, 8'd55);
        send_request(CMD_UNLOCK, 8'd5, 8'd0);
        send_request(CMD_UNLOCK, 8'd5, 8'd0);

        // random: contention episodes with hand-off, mixed with loose requests
        start = issued;
        while (issued - start < RANDOM_ITEMS)
        begin
            steady = (issued - start >= 300) && (issued - start < 550);
            if ($urandom_range(3) != 0)
            begin
                send_request(CMD_LOCK, pick_thread(), pick_prio());
                if ($urandom_range(4) == 0)
                    waiters = $urandom_range(18, 12);
                else
                    waiters = $urandom_range(6, 1);
                repeat (waiters)
                begin
                    send_request(CMD_LOCK, pick_thread(), pick_prio());
                    if ($urandom_range(9) == 0)
                        send_random_request();
                end
                // owner releases, the woken waiter comes back for the lock
                handoffs = $urandom_range(waiters + 1, 1);
                repeat (handoffs)
                begin
                    id = ($urandom_range(9) == 0) ? pick_thread() : ledger.holder;
                    send_request(CMD_UNLOCK, id, pick_prio());
                    if (ledger.woke)
                        send_request(($urandom_range(5) == 0) ? CMD_TRYLOCK : CMD_LOCK,
                                     ledger.woken_thread, pick_prio());
                    if ($urandom_range(9) == 0)
                        send_random_request();
                end
            end
            else
                repeat ($urandom_range(8, 1))
                    send_random_request();
        end
        steady = 1'b0;
        req.valid <= 1'b0;

        // drain outstanding responses
        while (ledger.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("priority_inheritance_lock_unit_tb passed");
        else
            $display("priority_inheritance_lock_unit_tb failed");
        $finish;
    end
endmodule
